### rtl/core/ibfr_pkg.sv
// ibfr_pkg: shared constants and types of the frame receiver.
// No dependencies; every other file of the block but ibfr_byte_if and ibfr_ram imports it.
`timescale 1ns / 1ps

package ibfr_pkg;

	localparam int NUM_CHANNELS = 14;

	localparam int CH_W    = 4;
	localparam int VAL_W   = 16;
	localparam int CNT_W   = 32;
	localparam int POS_W   = 5;

	// Payload buffer: 14 little-endian words, bytes 2..29 of a frame
	localparam int RAM_DEPTH = 14;
	localparam int RAM_AW    = 4;

	localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CHANNELS - 1);

	localparam logic [7:0]       HDR_FIRST  = 8'h20;
	localparam logic [7:0]       HDR_SECOND = 8'h40;
	localparam logic [VAL_W-1:0] CHK_BASE   = 16'hFFFF;

	// Byte positions inside a frame
	localparam logic [POS_W-1:0] POS_HUNT     = 5'd0;
	localparam logic [POS_W-1:0] POS_HDR2     = 5'd1;
	localparam logic [POS_W-1:0] POS_PAY      = 5'd2;
	localparam logic [POS_W-1:0] POS_FIRST_HI = 5'd3;
	localparam logic [POS_W-1:0] POS_PAY_END  = 5'd29;
	localparam logic [POS_W-1:0] POS_CHK_LO   = 5'd30;
	localparam logic [POS_W-1:0] POS_CHK_HI   = 5'd31;

	// Frame verdict passed from the front end to the back end
	typedef struct packed {
		logic             good;
		logic [CNT_W-1:0] good_frames;
		logic [CNT_W-1:0] bad_frames;
		logic             signal_present;
	} cmd_t;

endpackage

### rtl/core/ibfr_byte_if.sv
// ibfr_byte_if: valid/ready channel carrying one received serial byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface ibfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/core/ibfr_result_if.sv
// ibfr_result_if: valid/ready channel carrying one decoded channel or bad-frame result.
// Depends on ibfr_pkg for field widths.
`timescale 1ns / 1ps

interface ibfr_result_if import ibfr_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  channel_index;
	logic [VAL_W-1:0] channel_value;
	logic             frame_good;
	logic             last;
	logic [CNT_W-1:0] good_frames;
	logic [CNT_W-1:0] bad_frames;
	logic             signal_present;

	modport source (output valid, output channel_index, output channel_value,
		output frame_good, output last, output good_frames, output bad_frames,
		output signal_present, input ready);
	modport sink (input valid, input channel_index, input channel_value,
		input frame_good, input last, input good_frames, input bad_frames,
		input signal_present, output ready);
endinterface

### rtl/core/ibfr_ram.sv
// ibfr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ibfr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/ibfr_front.sv
// ibfr_front: header hunt, byte collection, checksum check and frame counters.
// Depends on ibfr_pkg and ibfr_byte_if; writes payload words into the buffer RAM.
`timescale 1ns / 1ps

module ibfr_front import ibfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ibfr_byte_if.sink         rx,
	input  logic              ram_busy,
	input  logic              q_full,
	output logic              q_push,
	output cmd_t              q_cmd,
	output logic              ram_we,
	output logic [RAM_AW-1:0] ram_waddr,
	output logic [VAL_W-1:0]  ram_wdata
);

	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] sum_q;
	logic [7:0]       lo_q;
	logic [CNT_W-1:0] good_q;
	logic [CNT_W-1:0] bad_q;
	logic             seen_q;

	logic             in_payload;
	logic             acc;
	logic [POS_W-1:0] pos_off;
	logic [VAL_W-1:0] sum_next;
	logic [VAL_W-1:0] rx_chk;
	logic             match;

	assign in_payload = (pos_q >= POS_PAY) && (pos_q <= POS_PAY_END);

	// Hold payload bytes while the buffer still feeds the back end, and the last byte while the queue is full
	always_comb begin
		if (in_payload) begin
			rx.ready = !ram_busy;
		end else if (pos_q == POS_CHK_HI) begin
			rx.ready = !q_full;
		end else begin
			rx.ready = 1'b1;
		end
	end

	assign acc      = rx.valid && rx.ready;
	assign sum_next = sum_q + VAL_W'(rx.rx_byte);
	assign pos_off  = pos_q - POS_FIRST_HI;

	assign ram_we    = acc && in_payload && pos_q[0];
	assign ram_waddr = pos_off[POS_W-1:1];
	assign ram_wdata = {rx.rx_byte, lo_q};

	assign rx_chk = {rx.rx_byte, lo_q};
	assign match  = (rx_chk == (CHK_BASE - sum_q));

	assign q_push = acc && (pos_q == POS_CHK_HI);
	always_comb begin
		q_cmd.good           = match;
		q_cmd.good_frames    = match ? good_q + CNT_W'(1) : good_q;
		q_cmd.bad_frames     = match ? bad_q : bad_q + CNT_W'(1);
		q_cmd.signal_present = seen_q || match;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HUNT;
			sum_q  <= '0;
			good_q <= '0;
			bad_q  <= '0;
			seen_q <= 1'b0;
		end else if (acc) begin
			if (pos_q == POS_HUNT) begin
				if (rx.rx_byte == HDR_FIRST) begin
					sum_q <= VAL_W'(rx.rx_byte);
					pos_q <= POS_HDR2;
				end
			end else if (pos_q == POS_HDR2) begin
				if (rx.rx_byte == HDR_SECOND) begin
					sum_q <= sum_next;
					pos_q <= POS_PAY;
				end else if (rx.rx_byte == HDR_FIRST) begin
					sum_q <= VAL_W'(rx.rx_byte);
				end else begin
					sum_q <= '0;
					pos_q <= POS_HUNT;
				end
			end else if (in_payload) begin
				sum_q <= sum_next;
				pos_q <= pos_q + POS_W'(1);
			end else if (pos_q == POS_CHK_LO) begin
				pos_q <= pos_q + POS_W'(1);
			end else begin
				pos_q  <= POS_HUNT;
				sum_q  <= '0;
				good_q <= q_cmd.good_frames;
				bad_q  <= q_cmd.bad_frames;
				seen_q <= q_cmd.signal_present;
			end
		end
	end

	// Low byte of a payload word, or of the checksum
	always_ff @(posedge clk) begin
		if (acc && (in_payload || pos_q == POS_CHK_LO)) begin
			lo_q <= rx.rx_byte;
		end
	end

endmodule

### rtl/core/ibfr_cmd_fifo.sv
// ibfr_cmd_fifo: two-entry queue of frame verdicts between front and back end.
// Depends on ibfr_pkg.
`timescale 1ns / 1ps

module ibfr_cmd_fifo import ibfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic valid,
	output cmd_t head,
	output logic full,
	output logic has_good
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic [1:0] ent_valid;

	assign valid = (count_q != 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = ent_q[rd_ptr_q];

	always_comb begin
		ent_valid[0] = full || (valid && !rd_ptr_q);
		ent_valid[1] = full || (valid && rd_ptr_q);
	end

	assign has_good = (ent_valid[0] && ent_q[0].good) || (ent_valid[1] && ent_q[1].good);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

### rtl/core/ibfr_back.sv
// ibfr_back: turns frame verdicts into result transactions, reading channels from the buffer.
// Depends on ibfr_pkg and ibfr_result_if.
`timescale 1ns / 1ps

module ibfr_back import ibfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cmd_t              q_cmd,
	output logic              q_pop,
	output logic              ram_re,
	output logic [RAM_AW-1:0] ram_raddr,
	input  logic [VAL_W-1:0]  ram_rdata,
	output logic              busy,
	ibfr_result_if.source     res
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_LOAD = 3'b100
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [CH_W-1:0]  ch_q;
	logic             out_valid_q;
	logic             slot_free;
	logic             load_bad;
	logic             load_ch;

	assign slot_free = !out_valid_q || res.ready;
	assign load_bad  = (state_q == S_IDLE) && q_valid && !q_cmd.good && slot_free;
	assign load_ch   = (state_q == S_LOAD) && slot_free;
	assign q_pop     = (state_q == S_IDLE) && q_valid && (q_cmd.good || slot_free);

	assign ram_re    = (state_q == S_READ);
	assign ram_raddr = RAM_AW'(ch_q);
	assign busy      = (state_q != S_IDLE);
	assign res.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_bad || load_ch) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid && q_cmd.good) begin
						ch_q    <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (slot_free) begin
						if (ch_q == CH_LAST) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register; read data stays in the RAM output until it is taken
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.good) begin
			cmd_q <= q_cmd;
		end
		if (load_bad) begin
			res.channel_index  <= '0;
			res.channel_value  <= '0;
			res.frame_good     <= 1'b0;
			res.last           <= 1'b1;
			res.good_frames    <= q_cmd.good_frames;
			res.bad_frames     <= q_cmd.bad_frames;
			res.signal_present <= q_cmd.signal_present;
		end else if (load_ch) begin
			res.channel_index  <= ch_q;
			res.channel_value  <= ram_rdata;
			res.frame_good     <= 1'b1;
			res.last           <= (ch_q == CH_LAST);
			res.good_frames    <= cmd_q.good_frames;
			res.bad_frames     <= cmd_q.bad_frames;
			res.signal_present <= cmd_q.signal_present;
		end
	end

endmodule

### rtl/core/ibus_frame_receiver.sv
// ibus_frame_receiver: top level of the RC receiver frame parser.
// Depends on ibfr_pkg, both channel interfaces, ibfr_front, ibfr_cmd_fifo, ibfr_back, ibfr_ram.
//
// Usage:
//   rx  : one serial byte per transaction. The receiver hunts for the header 0x20 0x40,
//         then collects a 32-byte frame and checks its 16-bit checksum.
//   res : per good frame, 14 transactions (channel 0..13, last on channel 13);
//         per bad frame, one transaction with frame_good low and last high.
//         Each carries the frame counters and the signal-present flag.
// Throughput: one byte per cycle on rx while ready is high. The back end emits each channel
//   through a registered buffer read, then the output register.
// Order: after the last frame byte is accepted, a good frame passes the queue, a registered
//   buffer read and the output register; a bad-frame result, the queue and the output register.
// Stall: a two-entry verdict queue parts the two sides. While buffered channels are
//   still being read, rx holds ready low on payload bytes of the next frame; rx also
//   stalls on the last frame byte when the queue is full. A stalled res holds its
//   result and lets the back end wait.
// Reset: arst_n clears position, checksum sum, counters, queue and output valid;
//   the block accepts bytes as soon as reset is released.
`timescale 1ns / 1ps

module ibus_frame_receiver import ibfr_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	ibfr_byte_if.sink     rx,
	ibfr_result_if.source res
);

	logic              q_push;
	cmd_t              q_push_cmd;
	logic              q_pop;
	logic              q_valid;
	cmd_t              q_head;
	logic              q_full;
	logic              q_has_good;
	logic              back_busy;
	logic              ram_busy;
	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [RAM_AW-1:0] ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;

	assign ram_busy = back_busy || q_has_good;

	ibfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.ram_busy  (ram_busy),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_push_cmd),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	ibfr_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head),
		.full     (q_full),
		.has_good (q_has_good)
	);

	ibfr_ram #(
		.WIDTH (VAL_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ibfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_head),
		.q_pop     (q_pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.busy      (back_busy),
		.res       (res)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("verdict pushed into a full queue");

	a_no_write_while_reading: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_busy)
		else $error("payload written while buffered channels are pending");

	a_bad_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.frame_good) |-> (res.last && res.channel_index == '0))
		else $error("bad-frame result with wrong index or last flag");

	a_good_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.frame_good) |-> (res.last == (res.channel_index == CH_LAST)))
		else $error("last flag not on the final channel");
`endif

endmodule
